@@ rtl/spav_pkg.sv @@
// Shared types, register codes and constants for the stall-protected velocity core.
package spav_pkg;

	localparam int unsigned FieldW   = 16;
	localparam int unsigned ThrW     = 15;
	localparam int unsigned CountW   = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned InDataW  = 96;
	localparam int unsigned OutDataW = 40;
	localparam int unsigned ProdW    = 33;
	localparam int unsigned ReqW     = ProdW - 8;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	localparam logic [15:0]     YawGainRst          = 16'd0;
	localparam logic [15:0]     PitchGainRst        = 16'd0;
	localparam logic [ThrW-1:0] YawSpeedLimRst      = 15'd0;
	localparam logic [ThrW-1:0] PitchSpeedLimRst    = 15'd0;
	localparam logic [ThrW-1:0] CommandThresholdRst = 15'd128;
	localparam logic [ThrW-1:0] SlowThresholdRst    = 15'd256;
	localparam logic [ThrW-1:0] TorqueThresholdRst  = 15'd128;
	localparam logic [15:0]     ConfirmTicksRst     = 16'd100;

	typedef enum logic [CfgIdxW-1:0] {
		REG_YAW_GAIN          = 3'd0,
		REG_PITCH_GAIN        = 3'd1,
		REG_YAW_SPEED_LIM     = 3'd2,
		REG_PITCH_SPEED_LIM   = 3'd3,
		REG_COMMAND_THRESHOLD = 3'd4,
		REG_SLOW_THRESHOLD    = 3'd5,
		REG_TORQUE_THRESHOLD  = 3'd6,
		REG_CONFIRM_TICKS     = 3'd7
	} cfg_reg_t;

	// Thresholds shared by both axes.
	typedef struct packed {
		logic [ThrW-1:0]   command_threshold;
		logic [ThrW-1:0]   slow_threshold;
		logic [ThrW-1:0]   torque_threshold;
		logic [CountW-1:0] confirm_ticks;
	} guard_cfg_t;

	typedef struct packed {
		logic [15:0]     yaw_gain;
		logic [15:0]     pitch_gain;
		logic [ThrW-1:0] yaw_speed_lim;
		logic [ThrW-1:0] pitch_speed_lim;
		guard_cfg_t      guard;
	} cfg_t;

endpackage

@@ rtl/spav_cfg_regs.sv @@
// Configuration register file written through the index/data write channel.
module spav_cfg_regs
	import spav_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_gain                <= YawGainRst;
			cfg_q.pitch_gain              <= PitchGainRst;
			cfg_q.yaw_speed_lim           <= YawSpeedLimRst;
			cfg_q.pitch_speed_lim         <= PitchSpeedLimRst;
			cfg_q.guard.command_threshold <= CommandThresholdRst;
			cfg_q.guard.slow_threshold    <= SlowThresholdRst;
			cfg_q.guard.torque_threshold  <= TorqueThresholdRst;
			cfg_q.guard.confirm_ticks     <= ConfirmTicksRst;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_YAW_GAIN:          cfg_q.yaw_gain <= cfg_data;
				REG_PITCH_GAIN:        cfg_q.pitch_gain <= cfg_data;
				REG_YAW_SPEED_LIM:     cfg_q.yaw_speed_lim <= cfg_data[ThrW-1:0];
				REG_PITCH_SPEED_LIM:   cfg_q.pitch_speed_lim <= cfg_data[ThrW-1:0];
				REG_COMMAND_THRESHOLD: cfg_q.guard.command_threshold <= cfg_data[ThrW-1:0];
				REG_SLOW_THRESHOLD:    cfg_q.guard.slow_threshold <= cfg_data[ThrW-1:0];
				REG_TORQUE_THRESHOLD:  cfg_q.guard.torque_threshold <= cfg_data[ThrW-1:0];
				REG_CONFIRM_TICKS:     cfg_q.guard.confirm_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/spav_axis.sv @@
// One axis: scaled and limited velocity request plus stall counter and latch.
module spav_axis
	import spav_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic signed [15:0] aim_err,
	input  logic signed [15:0] speed_fb,
	input  logic signed [15:0] torque_fb,
	input  logic [15:0]        gain,
	input  logic [ThrW-1:0]    speed_lim,
	input  guard_cfg_t         guard,
	output logic signed [15:0] command,
	output logic               stalled
);

	logic [CountW-1:0] count_q;
	logic              latch_q;
	logic [CountW-1:0] count_d;
	logic              latch_d;

	logic signed [ProdW-1:0] prod;
	logic signed [ReqW-1:0]  scaled;
	logic signed [ReqW-1:0]  lim_pos;
	logic signed [ReqW-1:0]  lim_neg;
	logic signed [15:0]      req;
	logic [15:0]             req_neg;
	logic [ThrW-1:0]         req_mag;
	logic [15:0]             vel_mag;
	logic [15:0]             trq_mag;
	logic [CountW-1:0]       count_inc;
	logic                    small_req;
	logic                    stall_tick;

	// Q8.8 times Q8.8, back to Q8.8 by an arithmetic shift (floor).
	assign prod    = aim_err * $signed({1'b0, gain});
	assign scaled  = $signed(prod[ProdW-1:8]);
	assign lim_pos = $signed({{(ReqW-ThrW){1'b0}}, speed_lim});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (scaled > lim_pos) begin
			req = lim_pos[15:0];
		end else if (scaled < lim_neg) begin
			req = lim_neg[15:0];
		end else begin
			req = scaled[15:0];
		end
	end

	assign req_neg = 16'(~req) + 16'd1;
	assign req_mag = req[15] ? req_neg[ThrW-1:0] : req[ThrW-1:0];
	assign vel_mag = speed_fb[15] ? 16'(~speed_fb) + 16'd1
		: speed_fb;
	assign trq_mag = torque_fb[15] ? 16'(~torque_fb) + 16'd1
		: torque_fb;

	assign small_req  = req_mag < guard.command_threshold;
	assign stall_tick = (vel_mag < {1'b0, guard.slow_threshold})
		&& (trq_mag > {1'b0, guard.torque_threshold});
	assign count_inc  = (count_q == CountMax) ? count_q : count_q + 16'd1;

	always_comb begin
		count_d = count_q;
		latch_d = latch_q;
		command = req;
		if (small_req) begin
			count_d = '0;
			latch_d = 1'b0;
			command = '0;
		end else if (latch_q) begin
			command = '0;
		end else if (stall_tick) begin
			count_d = count_inc;
			if (count_inc >= guard.confirm_ticks) begin
				latch_d = 1'b1;
				command = '0;
			end
		end else begin
			count_d = '0;
		end
	end

	assign stalled = latch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			latch_q <= 1'b0;
		end else if (step) begin
			count_q <= count_d;
			latch_q <= latch_d;
		end
	end

`ifndef SYNTHESIS
	// A latched axis never drives motion.
	a_latch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stalled |-> command == 16'sd0)
		else $error("stalled axis commands nonzero velocity");

	// The latch only sets after a counted stall tick.
	a_latch_rise: assert property (@(posedge clk) disable iff (!arst_n)
		step && !latch_q && latch_d |-> stall_tick && !small_req)
		else $error("stall latch set without stall tick");

	// A small request always clears the protection state.
	a_small_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step && small_req |=> count_q == '0 && !latch_q)
		else $error("small request did not clear stall state");
`endif

endmodule

@@ rtl/stall_protected_axis_velocity_core.sv @@
// Top level: stream ports, input register, two axis units and result register.
//
// Two-axis velocity command with stall protection. Each input word carries
// the yaw and pitch angle errors plus each motor's measured velocity and
// torque; each output word carries the limited velocity command for both
// axes and the two stall latches. Throughput is one word per clock while
// m_axis_tready keeps the output register draining: a word is captured in
// the input register, the multiply-by-gain, saturation and stall counter
// update happen in one combinational pass, and the result is held in the
// output register, which drives tvalid on the master side. The stall
// counters and latches advance only when a word moves into the output
// register, so back-pressure never skips or repeats a tick. The input side
// keeps accepting while a finished result waits, as long as the input
// register is free or moving on. Configuration writes are taken in any
// cycle (cfg_ready is always high) and must only be issued while no word is
// in flight.
module stall_protected_axis_velocity_core
	import spav_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// slave side word
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// [15:0] yaw aim error, [31:16] pitch aim error,
	// [47:32] yaw speed feedback, [63:48] yaw torque feedback,
	// [79:64] pitch speed feedback, [95:80] pitch torque feedback
	input  logic [InDataW-1:0]  s_axis_tdata,
	// master side word
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// [15:0] yaw_command, [31:16] pitch_command, [32] yaw_stalled,
	// [33] pitch_stalled, [39:34] zero
	output logic [OutDataW-1:0] m_axis_tdata,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg;

	logic               valid_s1;
	logic [InDataW-1:0] data_s1;
	logic               out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	logic               advance;

	logic signed [15:0] yaw_cmd;
	logic signed [15:0] pitch_cmd;
	logic               yaw_stl;
	logic               pitch_stl;

	assign cfg_ready = 1'b1;

	spav_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the input word on when the result register is empty or draining.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload: hold unless a new word is taken.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

	spav_axis u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.aim_err   ($signed(data_s1[15:0])),
		.speed_fb  ($signed(data_s1[47:32])),
		.torque_fb ($signed(data_s1[63:48])),
		.gain      (cfg.yaw_gain),
		.speed_lim (cfg.yaw_speed_lim),
		.guard     (cfg.guard),
		.command   (yaw_cmd),
		.stalled   (yaw_stl)
	);

	spav_axis u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.aim_err   ($signed(data_s1[31:16])),
		.speed_fb  ($signed(data_s1[79:64])),
		.torque_fb ($signed(data_s1[95:80])),
		.gain      (cfg.pitch_gain),
		.speed_lim (cfg.pitch_speed_lim),
		.guard     (cfg.guard),
		.command   (pitch_cmd),
		.stalled   (pitch_stl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {6'd0, pitch_stl, yaw_stl, pitch_cmd, yaw_cmd};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	// A latched yaw axis must report a zero command in the same word.
	a_yaw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[15:0] == 16'd0)
		else $error("yaw stalled with nonzero command");

	// Same for pitch.
	a_pitch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:16] == 16'd0)
		else $error("pitch stalled with nonzero command");

	// An empty input register always takes a word.
	a_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// A word leaving the input register shows up as a result next cycle.
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_axis_tvalid)
		else $error("word lost between input and result register");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the stall-protected two-axis velocity core.
module testbench;
	import spav_pkg::*;

	localparam int unsigned IdleLimit  = 4000;
	localparam int unsigned MaxReports = 10;
	localparam int unsigned RandPhases = 12;
	localparam int unsigned PhaseWords = 88;

	typedef logic [CfgDataW-1:0] reg_image_t [8];

	typedef struct {
		logic [CountW-1:0] count;
		logic              latched;
	} axis_track_t;

	typedef struct {
		logic [FieldW-1:0] yaw_cmd;
		logic [FieldW-1:0] pitch_cmd;
		logic              yaw_stalled;
		logic              pitch_stalled;
	} cmd_word_t;

	typedef struct {
		logic [FieldW-1:0] err;
		logic [FieldW-1:0] vel;
		logic [FieldW-1:0] trq;
	} axis_sample_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_MOSTLY
	} sink_mode_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// [15:0] yaw aim error, [31:16] pitch aim error,
	// [47:32] yaw speed feedback, [63:48] yaw torque feedback,
	// [79:64] pitch speed feedback, [95:80] pitch torque feedback
	logic [InDataW-1:0]  s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [15:0] yaw_command, [31:16] pitch_command, [32] yaw_stalled,
	// [33] pitch_stalled, [39:34] zero
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index     = '0;
	logic [CfgDataW-1:0] cfg_data      = '0;

	stall_protected_axis_velocity_core i_dut (.*);

	// predictor copy of the registers and both axes' stall state
	cfg_t        shadow_cfg;
	axis_track_t yaw_track;
	axis_track_t pitch_track;

	logic [InDataW-1:0] pending_words [$];
	cmd_word_t          expected_cmds [$];

	int unsigned words_in        = 0;
	int unsigned words_out       = 0;
	int unsigned stalled_words   = 0;
	int unsigned mismatches      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned settings_loaded = 0;
	int unsigned longest_hold    = 0;

	int unsigned burst_left   = 0;
	int unsigned gap_left     = 0;
	int unsigned hold_left    = 0;
	int unsigned pattern_left = 0;
	logic        hold_done    = 1'b0;
	sink_mode_t  sink_mode    = SINK_OPEN;
	logic        moved;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int magnitude(logic [FieldW-1:0] v);
		int s;
		s = int'($signed(v));
		return (s < 0) ? -s : s;
	endfunction

	// Q8.8 error times Q8.8 gain, floor shift back to Q8.8, clamp to +/- limit.
	function automatic logic [FieldW-1:0] limited_request(logic [FieldW-1:0] err,
			logic [15:0] gain, logic [ThrW-1:0] vmax);
		longint prod;
		longint req;
		longint lim;
		prod = longint'($signed(err)) * longint'(gain);
		req  = prod >>> 8;
		lim  = longint'(vmax);
		if (req > lim)
			req = lim;
		if (req < -lim)
			req = -lim;
		return req[FieldW-1:0];
	endfunction

	function automatic logic [FieldW-1:0] guarded_command(inout axis_track_t st,
			input logic [FieldW-1:0] req, input logic [FieldW-1:0] vel,
			input logic [FieldW-1:0] trq);
		if (magnitude(req) < int'(shadow_cfg.guard.command_threshold)) begin
			st.count   = '0;
			st.latched = 1'b0;
			return '0;
		end
		if (st.latched)
			return '0;
		if (magnitude(vel) < int'(shadow_cfg.guard.slow_threshold) &&
		    magnitude(trq) > int'(shadow_cfg.guard.torque_threshold)) begin
			if (st.count != CountMax)
				st.count = st.count + 1'b1;
			if (st.count >= shadow_cfg.guard.confirm_ticks) begin
				st.latched = 1'b1;
				return '0;
			end
		end else begin
			st.count = '0;
		end
		return req;
	endfunction

	function automatic cmd_word_t predict_tick(logic [InDataW-1:0] w);
		cmd_word_t r;
		r.yaw_cmd = guarded_command(yaw_track,
			limited_request(w[15:0], shadow_cfg.yaw_gain, shadow_cfg.yaw_speed_lim),
			w[47:32], w[63:48]);
		r.pitch_cmd = guarded_command(pitch_track,
			limited_request(w[31:16], shadow_cfg.pitch_gain, shadow_cfg.pitch_speed_lim),
			w[79:64], w[95:80]);
		r.yaw_stalled   = yaw_track.latched;
		r.pitch_stalled = pitch_track.latched;
		return r;
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= MaxReports)
			$display("mismatch on result word %0d, %s: expected %h, got %h",
				words_out, what, want, got);
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h0100;
			3: return 16'($urandom_range(0, 1024));
			default: return 16'($urandom);
		endcase
	endfunction

	// bit 15 of a 15-bit register is written now and then; the block drops it
	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 600));
			3: return 16'($urandom_range(0, 4000));
			4: return 16'($urandom);
			default: return 16'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic reg_image_t random_settings();
		reg_image_t v;
		v[REG_YAW_GAIN]          = pick_gain();
		v[REG_PITCH_GAIN]        = pick_gain();
		v[REG_YAW_SPEED_LIM]     = pick_level();
		v[REG_PITCH_SPEED_LIM]   = pick_level();
		v[REG_COMMAND_THRESHOLD] = pick_level();
		v[REG_SLOW_THRESHOLD]    = pick_level();
		v[REG_TORQUE_THRESHOLD]  = pick_level();
		case ($urandom_range(0, 9))
			0: v[REG_CONFIRM_TICKS] = 16'h0000;
			1: v[REG_CONFIRM_TICKS] = 16'hFFFF;
			2: v[REG_CONFIRM_TICKS] = 16'($urandom);
			default: v[REG_CONFIRM_TICKS] = 16'($urandom_range(1, 12));
		endcase
		return v;
	endfunction

	// Mostly slow motion under high torque so counters climb and latch; some
	// tiny or extreme errors mixed in, and the rest left as raw noise.
	function automatic axis_sample_t random_axis(int slow, int push);
		axis_sample_t a;
		int pick;
		int m;
		pick  = $urandom_range(0, 99);
		a.err = 16'($urandom);
		a.vel = 16'($urandom);
		a.trq = 16'($urandom);
		if (pick < 8)
			a.err = 16'(int'($urandom_range(0, 16)) - 8);
		else if (pick < 14)
			a.err = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
		if (pick < 75) begin
			if (slow > 0) begin
				m     = $urandom_range(0, slow - 1);
				a.vel = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
			end
			if (push < 32767) begin
				m     = $urandom_range(32767, push + 1);
				a.trq = $urandom_range(0, 1) ? 16'(m) : 16'(-m);
			end else begin
				a.trq = 16'h8000;
			end
		end
		return a;
	endfunction

	task automatic queue_tick(input logic [15:0] yaw_err, input logic [15:0] pitch_err,
			input logic [15:0] yaw_vel, input logic [15:0] yaw_trq,
			input logic [15:0] pitch_vel, input logic [15:0] pitch_trq);
		pending_words.push_back({pitch_trq, pitch_vel, yaw_trq, yaw_vel, pitch_err, yaw_err});
	endtask

	// Hold cfg_valid high across all eight writes; lower it once at the end.
	task automatic program_regs(input reg_image_t vals);
		for (int i = 0; i < 8; i++) begin
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	task automatic set_all(input logic [15:0] yaw_gain, input logic [15:0] pitch_gain,
			input logic [15:0] yaw_max, input logic [15:0] pitch_max,
			input logic [15:0] cmd_thr, input logic [15:0] slow_thr,
			input logic [15:0] push_thr, input logic [15:0] confirm);
		reg_image_t v;
		v[REG_YAW_GAIN]          = yaw_gain;
		v[REG_PITCH_GAIN]        = pitch_gain;
		v[REG_YAW_SPEED_LIM]     = yaw_max;
		v[REG_PITCH_SPEED_LIM]   = pitch_max;
		v[REG_COMMAND_THRESHOLD] = cmd_thr;
		v[REG_SLOW_THRESHOLD]    = slow_thr;
		v[REG_TORQUE_THRESHOLD]  = push_thr;
		v[REG_CONFIRM_TICKS]     = confirm;
		program_regs(v);
	endtask

	// Wait until every queued word is taken and answered, then let the
	// pipeline drain before touching the registers.
	task automatic settle();
		while (pending_words.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sender: bursts of random length, random gaps between them, a gap of
	// zero now and then so long unbroken stretches occur too.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0 || pending_words.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= pending_words.pop_front();
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end
		end
	end

	// Receiver: a stall pattern that changes every so often, plus long
	// hold-offs while the sender is offering so the core backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (s_axis_tvalid &&
		             ((!hold_done && words_in >= 200) || $urandom_range(0, 1499) == 0)) begin
			hold_left = $urandom_range(40, 120);
			hold_done = 1'b1;
			if (hold_left > longest_hold)
				longest_hold = hold_left;
			m_axis_tready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				sink_mode    = sink_mode_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(8, 150);
			end else begin
				pattern_left--;
			end
			case (sink_mode)
				SINK_OPEN:   m_axis_tready <= 1'b1;
				SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
				default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Monitor: track register writes, predict each accepted word, check results.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_reg_t'(cfg_index))
					REG_YAW_GAIN:          shadow_cfg.yaw_gain = cfg_data;
					REG_PITCH_GAIN:        shadow_cfg.pitch_gain = cfg_data;
					REG_YAW_SPEED_LIM:     shadow_cfg.yaw_speed_lim = cfg_data[ThrW-1:0];
					REG_PITCH_SPEED_LIM:   shadow_cfg.pitch_speed_lim = cfg_data[ThrW-1:0];
					REG_COMMAND_THRESHOLD: shadow_cfg.guard.command_threshold = cfg_data[ThrW-1:0];
					REG_SLOW_THRESHOLD:    shadow_cfg.guard.slow_threshold = cfg_data[ThrW-1:0];
					REG_TORQUE_THRESHOLD:  shadow_cfg.guard.torque_threshold = cfg_data[ThrW-1:0];
					REG_CONFIRM_TICKS:     shadow_cfg.guard.confirm_ticks = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				expected_cmds.push_back(predict_tick(s_axis_tdata));
				words_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				words_out++;
				if (expected_cmds.size() == 0) begin
					note_mismatch("word with nothing pending", '0, m_axis_tdata[31:0]);
				end else begin
					cmd_word_t want;
					want = expected_cmds.pop_front();
					if (want.yaw_stalled || want.pitch_stalled)
						stalled_words++;
					if (m_axis_tdata[15:0] !== want.yaw_cmd)
						note_mismatch("yaw_command", 32'(want.yaw_cmd),
							32'(m_axis_tdata[15:0]));
					if (m_axis_tdata[31:16] !== want.pitch_cmd)
						note_mismatch("pitch_command", 32'(want.pitch_cmd),
							32'(m_axis_tdata[31:16]));
					if (m_axis_tdata[32] !== want.yaw_stalled)
						note_mismatch("yaw_stalled", 32'(want.yaw_stalled),
							32'(m_axis_tdata[32]));
					if (m_axis_tdata[33] !== want.pitch_stalled)
						note_mismatch("pitch_stalled", 32'(want.pitch_stalled),
							32'(m_axis_tdata[33]));
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	initial begin
		wait (arst_n);
		while (idle_cycles < IdleLimit)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", IdleLimit);
		$display("testbench: errors");
		$finish;
	end

	initial begin
		reg_image_t regs;
		axis_sample_t ya;
		axis_sample_t pa;

		shadow_cfg.yaw_gain                = YawGainRst;
		shadow_cfg.pitch_gain              = PitchGainRst;
		shadow_cfg.yaw_speed_lim           = YawSpeedLimRst;
		shadow_cfg.pitch_speed_lim         = PitchSpeedLimRst;
		shadow_cfg.guard.command_threshold = CommandThresholdRst;
		shadow_cfg.guard.slow_threshold    = SlowThresholdRst;
		shadow_cfg.guard.torque_threshold  = TorqueThresholdRst;
		shadow_cfg.guard.confirm_ticks     = ConfirmTicksRst;
		yaw_track   = '{count: '0, latched: 1'b0};
		pitch_track = '{count: '0, latched: 1'b0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gain, every request falls under the threshold
		queue_tick(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 16'h8000);
		queue_tick(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF);
		settle();

		// unity gain, confirm after three ticks
		set_all(16'h0100, 16'h0100, 16'h7FFF, 16'h7FFF, 16'd128, 16'd256, 16'd128, 16'd3);
		// count up, latch on the third tick, stay latched
		repeat (4) queue_tick(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h00FF, 16'h8000);
		// small request clears count and latch
		queue_tick(16'h0010, 16'hFFF0, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
		// speed right at the slow threshold does not count
		queue_tick(16'h0100, 16'hFF00, 16'h0100, 16'h7FFF, 16'hFF00, 16'h7FFF);
		// request right at the command threshold passes; torque at threshold
		queue_tick(16'h0080, 16'hFF80, 16'h8000, 16'h0081, 16'h0000, 16'h0080);
		queue_tick(16'h007F, 16'hFF81, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
		settle();

		// half gain, zero command and torque thresholds, zero confirm count
		set_all(16'h0080, 16'h0080, 16'h7FFF, 16'h7FFF, 16'd0, 16'h7FFF, 16'd0, 16'd0);
		// floor rounding of negative products
		queue_tick(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		// first stall tick latches with a zero confirm count
		queue_tick(16'hFFFE, 16'h0003, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF);
		// nothing is small with a zero threshold: latch holds
		queue_tick(16'h7FFF, 16'h8000, 16'h8000, 16'h0001, 16'h7FFF, 16'h0001);
		settle();

		// full gain, zero yaw maximum, bit 15 set on pitch maximum and slow threshold
		set_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd1, 16'hFFFF, 16'h7FFF, 16'hFFFF);
		queue_tick(16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000);
		queue_tick(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
		queue_tick(16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000, 16'h8000);
		settle();

		// random settings, each followed by stall-shaped random words
		for (int phase = 0; phase < RandPhases; phase++) begin
			regs = random_settings();
			program_regs(regs);
			for (int n = 0; n < PhaseWords; n++) begin
				ya = random_axis(int'(regs[REG_SLOW_THRESHOLD][ThrW-1:0]),
					int'(regs[REG_TORQUE_THRESHOLD][ThrW-1:0]));
				pa = random_axis(int'(regs[REG_SLOW_THRESHOLD][ThrW-1:0]),
					int'(regs[REG_TORQUE_THRESHOLD][ThrW-1:0]));
				queue_tick(ya.err, pa.err, ya.vel, ya.trq, pa.vel, pa.trq);
			end
			settle();
		end

		$display("summary: %0d words in, %0d words out across %0d register settings",
			words_in, words_out, settings_loaded);
		$display("summary: %0d results with a stall latch set, longest output hold-off %0d cycles",
			stalled_words, longest_hold);
		if (mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/spav_pkg.sv
rtl/spav_cfg_regs.sv
rtl/spav_axis.sv
rtl/stall_protected_axis_velocity_core.sv
sim/testbench.sv
